// File: rtl/rlpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants of the rgb led pulse encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WordW   = 3 * ChanW;
  localparam int unsigned DurW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW    = 6;

  localparam logic [DurW-1:0] ZERO_HIGH_CYCLES = 16'd35;
  localparam logic [DurW-1:0] ZERO_LOW_CYCLES  = 16'd80;
  localparam logic [DurW-1:0] ONE_HIGH_CYCLES  = 16'd70;
  localparam logic [DurW-1:0] ONE_LOW_CYCLES   = 16'd60;
  localparam logic [DurW-1:0] LATCH_CYCLES     = 16'd5100;

  // index of the final segment of a pixel
  localparam logic [CntW-1:0] LAST_SEG = CntW'(2 * WordW - 1);

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_LATCH = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORDER      = 2'd1;

  localparam logic [1:0] ORDER_RGB = 2'd0;
  localparam logic [1:0] ORDER_GRB = 2'd1;
  localparam logic [1:0] ORDER_BRG = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] word;
  } item_t;

  typedef struct packed {
    logic [ChanW-1:0] factor;
    logic [1:0]       order;
  } cfg_t;

endpackage

// File: rtl/rlpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_front
// Input register with brightness scaling and channel ordering.
// ----------------------------------------------------------------------------
module rlpe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [rlpe_pkg::ChanW-1:0]    red_i,
  input  logic [rlpe_pkg::ChanW-1:0]    green_i,
  input  logic [rlpe_pkg::ChanW-1:0]    blue_i,
  input  rlpe_pkg::cfg_t                cfg_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output rlpe_pkg::item_t               item_o
);
  import rlpe_pkg::*;

  logic             full_q, full_d;
  logic             mode_q;
  logic [ChanW-1:0] red_q, green_q, blue_q;
  logic [ChanW-1:0] red_s, green_s, blue_s;
  logic             take;

  function automatic logic [ChanW-1:0] scale(input logic [ChanW-1:0] c,
                                             input logic [ChanW-1:0] f);
    logic [2*ChanW-1:0] p;
    p = (2*ChanW)'(c) * (2*ChanW)'(f);
    if (f == '0) begin
      return c;
    end
    return p[2*ChanW-1:ChanW];
  endfunction

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !full_q || item_ready_i;

  always_comb begin
    full_d = full_q;
    if (item_ready_i) begin
      full_d = 1'b0;
    end
    if (take) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q  <= mode_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  assign red_s   = scale(red_q, cfg_i.factor);
  assign green_s = scale(green_q, cfg_i.factor);
  assign blue_s  = scale(blue_q, cfg_i.factor);

  always_comb begin
    item_o.mode = mode_q;
    case (cfg_i.order)
      ORDER_GRB: item_o.word = {green_s, red_s, blue_s};
      ORDER_BRG: item_o.word = {blue_s, red_s, green_s};
      default:   item_o.word = {red_s, green_s, blue_s};
    endcase
  end

  assign item_valid_o = full_q;

endmodule

// File: rtl/rlpe_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_serializer
// Turns one pixel or latch into its sequence of line segments.
// ----------------------------------------------------------------------------
module rlpe_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  rlpe_pkg::item_t             item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        line_level_o,
  output logic [rlpe_pkg::DurW-1:0]   duration_cycles_o,
  output logic                        last_o
);
  import rlpe_pkg::*;

  logic             busy_q, busy_d;
  logic             mode_q;
  logic [WordW-1:0] word_q;
  logic [CntW-1:0]  cnt_q;
  logic             bit_one;
  logic             done;

  assign bit_one      = word_q[WordW-1];
  assign out_valid_o  = busy_q;
  // even count is the high half of a bit
  assign line_level_o = (mode_q == MODE_PIXEL) && !cnt_q[0];
  assign last_o       = (mode_q == MODE_LATCH) || (cnt_q == LAST_SEG);

  always_comb begin
    if (mode_q == MODE_LATCH) begin
      duration_cycles_o = LATCH_CYCLES;
    end else if (!cnt_q[0]) begin
      duration_cycles_o = bit_one ? ONE_HIGH_CYCLES : ZERO_HIGH_CYCLES;
    end else begin
      duration_cycles_o = bit_one ? ONE_LOW_CYCLES : ZERO_LOW_CYCLES;
    end
  end

  assign done         = out_ready_i && last_o;
  assign item_ready_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    if (item_ready_o) begin
      busy_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (item_ready_o) begin
        cnt_q <= '0;
      end else if (out_ready_i) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      mode_q <= item_i.mode;
      word_q <= item_i.word;
    end else if (busy_q && out_ready_i && cnt_q[0]) begin
      // low half done, move to next bit
      word_q <= {word_q[WordW-2:0], 1'b0};
    end
  end

endmodule

// File: rtl/rgb_led_pulse_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder
// Serial pulse encoder for a chain of rgb leds on one data line.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    mode, red, green, blue
//   out      output     out_valid / out_ready  line_level, duration_cycles, last
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an input word is held in the front register, where it is scaled and
// ordered; the serializer then hands out one segment per out handshake:
// 48 segments per pixel and 1 per latch. the front register takes the next
// word while the serializer is busy. reset clears the valid flags and both
// configuration registers.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [rlpe_pkg::ChanW-1:0]    red_i,
  input  logic [rlpe_pkg::ChanW-1:0]    green_i,
  input  logic [rlpe_pkg::ChanW-1:0]    blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_level_o,
  output logic [rlpe_pkg::DurW-1:0]     duration_cycles_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rlpe_pkg::ChanW-1:0]    cfg_data_i
);
  import rlpe_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BRIGHTNESS: cfg_q.factor <= cfg_data_i;
        CFG_ORDER:      cfg_q.order  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  rlpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .cfg_i        (cfg_q),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  rlpe_serializer u_ser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_ready_o      (item_ready),
    .item_i            (item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .line_level_o      (line_level_o),
    .duration_cycles_o (duration_cycles_o),
    .last_o            (last_o)
  );

endmodule

// File: rtl/rlpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_checker
// Port-level checks of the rgb led pulse encoder.
// ----------------------------------------------------------------------------
module rlpe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        line_level_o,
  input logic [rlpe_pkg::DurW-1:0]   duration_cycles_o,
  input logic                        last_o
);
  import rlpe_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_level_o)
      && $stable(duration_cycles_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // an item keeps producing segments until its last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("segment stream broke before last");

  a_high_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_level_o |-> !last_o)
    else $error("high segment flagged last");

  // input only backs up behind a busy output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with idle output");

  a_high_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_level_o |->
      (duration_cycles_o == ONE_HIGH_CYCLES) || (duration_cycles_o == ZERO_HIGH_CYCLES))
    else $error("bad high segment duration");

endmodule

bind rgb_led_pulse_encoder rlpe_checker u_rlpe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .line_level_o      (line_level_o),
  .duration_cycles_o (duration_cycles_o),
  .last_o            (last_o)
);
